// File: hdl/meah_pkg.sv
// Shared types and constants for the MIPS execute stage with HI/LO unit.
`timescale 1ns / 1ps

package meah_pkg;

    localparam int DATA_W    = 32;
    localparam int IMM_W     = 16;
    localparam int SH_W      = 5;
    localparam int CMD_W     = 5;
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 40;

    // Bit positions in m_tdata
    localparam int M_WE_BIT  = 32;
    localparam int M_OVF_BIT = 33;
    localparam int M_HOV_BIT = 34;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 5'd0,
        CMD_ADDU  = 5'd1,
        CMD_SUB   = 5'd2,
        CMD_AND   = 5'd3,
        CMD_OR    = 5'd4,
        CMD_XOR   = 5'd5,
        CMD_NOR   = 5'd6,
        CMD_NAND  = 5'd7,
        CMD_SLT   = 5'd8,
        CMD_SLL   = 5'd9,
        CMD_SRL   = 5'd10,
        CMD_SRA   = 5'd11,
        CMD_MULT  = 5'd12,
        CMD_MULTU = 5'd13,
        CMD_MFHI  = 5'd14,
        CMD_MFLO  = 5'd15,
        CMD_ADDI  = 5'd16,
        CMD_ADDIU = 5'd17,
        CMD_LUI   = 5'd18,
        CMD_ANDI  = 5'd19,
        CMD_ORI   = 5'd20,
        CMD_NORI  = 5'd21,
        CMD_SLTI  = 5'd22
    } cmd_t;

endpackage

// File: hdl/mips_execute_alu_hilo.sv
// Execute stage of a MIPS-like core: ALU, shifter and HI/LO multiplier.
//
// Input stream (s_): one instruction word per handshake. s_tuser carries the
// command code, s_tdata the operands. Output stream (m_): one result word per
// instruction, in order, with the value and its write/overflow/overwrite flags.
//
// Path: an accepted word goes into the input register, then through the
// ALU/multiplier logic into the output register that drives m_tvalid.
// Throughput: one word per cycle unless m_tready stalls; the 33x33 multiplier
// sits in the logic before the output register and writes HI/LO with it, so
// mfhi/mflo right behind a mult sees the new product.
//
// Reset (aresetn low, synchronous): both stages empty, HI, LO and the
// unread-product flag cleared.
// Stall: while m_tready is low the output word holds; one more word is still
// taken into the input register, after which s_tready drops until the
// output register drains.
`timescale 1ns / 1ps

module mips_execute_alu_hilo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // rs_value[31:0], rt_value[63:32], immediate[79:64], shift_amount[84:80],
    // dest_is_zero[85], zero pad[87:86]
    input  logic [meah_pkg::S_TDATA_W-1:0] s_tdata,
    // command[4:0]
    input  logic [meah_pkg::CMD_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // result_value[31:0], write_enable[32], overflow[33], hilo_overwrite[34],
    // zero pad[39:35]
    output logic [meah_pkg::M_TDATA_W-1:0] m_tdata
);
    import meah_pkg::*;

    // input stage
    logic                in_valid_reg;
    logic [CMD_W-1:0]    in_cmd_reg;
    logic [DATA_W-1:0]   in_rs_reg;
    logic [DATA_W-1:0]   in_rt_reg;
    logic [IMM_W-1:0]    in_imm_reg;
    logic [SH_W-1:0]     in_sh_reg;
    logic                in_dz_reg;

    // output stage
    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_val_reg;
    logic                out_we_reg;
    logic                out_ovf_reg;
    logic                out_hov_reg;

    // architectural state
    logic [DATA_W-1:0]   hi_reg;
    logic [DATA_W-1:0]   lo_reg;
    logic                pending_reg;

    logic [DATA_W-1:0]   hi_next;
    logic [DATA_W-1:0]   lo_next;
    logic                pending_next;
    logic [DATA_W-1:0]   val_next;
    logic                we_next;
    logic                ovf_next;
    logic                hov_next;

    logic                out_free;
    logic                advance;
    logic                s_accept;

    cmd_t                cmd;
    logic [DATA_W-1:0]   imm_sext;
    logic [DATA_W-1:0]   imm_zext;
    logic [DATA_W-1:0]   add_sum;
    logic [DATA_W-1:0]   sub_diff;
    logic [DATA_W-1:0]   addi_sum;
    logic signed [DATA_W:0]     mul_a;
    logic signed [DATA_W:0]     mul_b;
    logic signed [2*DATA_W+1:0] prod;
    logic                       mul_signed;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - DATA_W - 3){1'b0}},
                       out_hov_reg, out_ovf_reg, out_we_reg, out_val_reg};

    // operand forms and the shared adders
    assign cmd        = cmd_t'(in_cmd_reg);
    assign imm_sext   = {{(DATA_W - IMM_W){in_imm_reg[IMM_W-1]}}, in_imm_reg};
    assign imm_zext   = {{(DATA_W - IMM_W){1'b0}}, in_imm_reg};
    assign add_sum    = in_rs_reg + in_rt_reg;
    assign sub_diff   = in_rs_reg - in_rt_reg;
    assign addi_sum   = in_rs_reg + imm_sext;
    assign mul_signed = (cmd == CMD_MULT);
    assign mul_a      = $signed({mul_signed & in_rs_reg[DATA_W-1], in_rs_reg});
    assign mul_b      = $signed({mul_signed & in_rt_reg[DATA_W-1], in_rt_reg});
    assign prod       = mul_a * mul_b;

    always_comb begin
        val_next     = '0;
        we_next      = 1'b1;
        ovf_next     = 1'b0;
        hov_next     = 1'b0;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        pending_next = pending_reg;
        case (cmd)
            CMD_ADD: begin
                val_next = add_sum;
                ovf_next = (in_rs_reg[DATA_W-1] == in_rt_reg[DATA_W-1])
                           && (add_sum[DATA_W-1] != in_rs_reg[DATA_W-1]);
            end
            CMD_ADDU:  val_next = add_sum;
            CMD_SUB: begin
                val_next = sub_diff;
                ovf_next = (in_rs_reg[DATA_W-1] != in_rt_reg[DATA_W-1])
                           && (sub_diff[DATA_W-1] != in_rs_reg[DATA_W-1]);
            end
            CMD_AND:   val_next = in_rs_reg & in_rt_reg;
            CMD_OR:    val_next = in_rs_reg | in_rt_reg;
            CMD_XOR:   val_next = in_rs_reg ^ in_rt_reg;
            CMD_NOR:   val_next = ~(in_rs_reg | in_rt_reg);
            CMD_NAND:  val_next = ~(in_rs_reg & in_rt_reg);
            CMD_SLT:   val_next = {{(DATA_W-1){1'b0}},
                                   $signed(in_rs_reg) < $signed(in_rt_reg)};
            CMD_SLL:   val_next = in_rt_reg << in_sh_reg;
            CMD_SRL:   val_next = in_rt_reg >> in_sh_reg;
            CMD_SRA:   val_next = $unsigned($signed(in_rt_reg) >>> in_sh_reg);
            CMD_MULT, CMD_MULTU: begin
                we_next      = 1'b0;
                hov_next     = pending_reg;
                hi_next      = prod[2*DATA_W-1:DATA_W];
                lo_next      = prod[DATA_W-1:0];
                pending_next = 1'b1;
            end
            CMD_MFHI: begin
                val_next     = hi_reg;
                pending_next = 1'b0;
            end
            CMD_MFLO: begin
                val_next     = lo_reg;
                pending_next = 1'b0;
            end
            CMD_ADDI: begin
                val_next = addi_sum;
                ovf_next = (in_rs_reg[DATA_W-1] == imm_sext[DATA_W-1])
                           && (addi_sum[DATA_W-1] != in_rs_reg[DATA_W-1]);
            end
            CMD_ADDIU: val_next = addi_sum;
            CMD_LUI:   val_next = {in_imm_reg, {(DATA_W - IMM_W){1'b0}}};
            CMD_ANDI:  val_next = in_rs_reg & imm_zext;
            CMD_ORI:   val_next = in_rs_reg | imm_zext;
            CMD_NORI:  val_next = ~(in_rs_reg | imm_zext);
            CMD_SLTI:  val_next = {{(DATA_W-1){1'b0}},
                                   $signed(in_rs_reg) < $signed(imm_sext)};
            default:   we_next  = 1'b0;
        endcase
        if (in_dz_reg) begin
            we_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            pending_reg   <= 1'b0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                hi_reg        <= hi_next;
                lo_reg        <= lo_next;
                pending_reg   <= pending_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_cmd_reg <= s_tuser;
            in_rs_reg  <= s_tdata[DATA_W-1:0];
            in_rt_reg  <= s_tdata[2*DATA_W-1:DATA_W];
            in_imm_reg <= s_tdata[2*DATA_W+IMM_W-1:2*DATA_W];
            in_sh_reg  <= s_tdata[2*DATA_W+IMM_W+SH_W-1:2*DATA_W+IMM_W];
            in_dz_reg  <= s_tdata[2*DATA_W+IMM_W+SH_W];
        end
        if (advance) begin
            out_val_reg <= val_next;
            out_we_reg  <= we_next;
            out_ovf_reg <= ovf_next;
            out_hov_reg <= hov_next;
        end
    end

endmodule

// File: hdl/meah_checker.sv
// Port-level checks for the execute stage, bound to the top level.
`timescale 1ns / 1ps

module meah_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [meah_pkg::M_TDATA_W-1:0] m_tdata
);
    import meah_pkg::*;

    // nothing comes out of a freshly reset block
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // an overwrite flag only comes from a multiply, which never writes a register
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[M_HOV_BIT] |-> !m_tdata[M_WE_BIT])
        else $error("overwrite flag with write enable");

    // multiplies that set the overwrite flag report no overflow and a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[M_HOV_BIT]
            |-> !m_tdata[M_OVF_BIT] && (m_tdata[DATA_W-1:0] == '0))
        else $error("overwrite flag with overflow or nonzero value");

endmodule

bind mips_execute_alu_hilo meah_checker u_meah_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: dv/mips_execute_alu_hilo_test.sv
// Self-checking stream testbench for the MIPS execute stage with HI/LO unit.
`timescale 1ns / 1ps

module mips_execute_alu_hilo_test;
    import meah_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 5'd23;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 5'd31;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] rs;
        logic [DATA_W-1:0] rt;
        logic [IMM_W-1:0]  imm;
        logic [SH_W-1:0]   sh;
        logic              dz;
    } instr_t;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic              wr_en;
        logic              ovf;
        logic              hilo_ovw;
    } exec_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [CMD_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;

    // Predictor copy of the block state
    logic [DATA_W-1:0] hi_copy;
    logic [DATA_W-1:0] lo_copy;
    logic              product_unread;

    exec_result_t exec_results_due[$];
    int error_count;
    int tx_gap_max;
    int rx_gap_max;
    int rx_hold_cycles;

    mips_execute_alu_hilo uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [DATA_W-1:0] sext_imm(logic [IMM_W-1:0] imm);
        return {{(DATA_W-IMM_W){imm[IMM_W-1]}}, imm};
    endfunction

    function automatic logic add_overflows(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                           logic [DATA_W-1:0] s);
        logic [DATA_W-1:0] ov_bits;
        ov_bits = ~(a ^ b) & (a ^ s);
        return ov_bits[DATA_W-1];
    endfunction

    function automatic exec_result_t predict_execute(instr_t w);
        exec_result_t r;
        logic [DATA_W-1:0] ext;
        logic [DATA_W-1:0] ov_bits;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] prod;
        logic writes;
        r = '{value: '0, wr_en: 1'b0, ovf: 1'b0, hilo_ovw: 1'b0};
        writes = 1'b1;
        ext = sext_imm(w.imm);
        case (w.cmd)
            CMD_ADD: begin
                r.value = w.rs + w.rt;
                r.ovf = add_overflows(w.rs, w.rt, r.value);
            end
            CMD_ADDU:  r.value = w.rs + w.rt;
            CMD_SUB: begin
                r.value = w.rs - w.rt;
                ov_bits = (w.rs ^ w.rt) & (w.rs ^ r.value);
                r.ovf = ov_bits[DATA_W-1];
            end
            CMD_AND:   r.value = w.rs & w.rt;
            CMD_OR:    r.value = w.rs | w.rt;
            CMD_XOR:   r.value = w.rs ^ w.rt;
            CMD_NOR:   r.value = ~(w.rs | w.rt);
            CMD_NAND:  r.value = ~(w.rs & w.rt);
            CMD_SLT:   r.value = ($signed(w.rs) < $signed(w.rt)) ? 32'd1 : 32'd0;
            CMD_SLL:   r.value = w.rt << w.sh;
            CMD_SRL:   r.value = w.rt >> w.sh;
            CMD_SRA:   r.value = $signed(w.rt) >>> w.sh;
            CMD_MULT, CMD_MULTU: begin
                if (w.cmd == CMD_MULT) begin
                    a = {{32{w.rs[31]}}, w.rs};
                    b = {{32{w.rt[31]}}, w.rt};
                end else begin
                    a = {32'd0, w.rs};
                    b = {32'd0, w.rt};
                end
                prod = a * b;
                r.hilo_ovw = product_unread;
                hi_copy = prod[63:32];
                lo_copy = prod[31:0];
                product_unread = 1'b1;
                writes = 1'b0;
            end
            CMD_MFHI: begin
                r.value = hi_copy;
                product_unread = 1'b0;
            end
            CMD_MFLO: begin
                r.value = lo_copy;
                product_unread = 1'b0;
            end
            CMD_ADDI: begin
                r.value = w.rs + ext;
                r.ovf = add_overflows(w.rs, ext, r.value);
            end
            CMD_ADDIU: r.value = w.rs + ext;
            CMD_LUI:   r.value = {w.imm, 16'd0};
            CMD_ANDI:  r.value = w.rs & {16'd0, w.imm};
            CMD_ORI:   r.value = w.rs | {16'd0, w.imm};
            CMD_NORI:  r.value = ~(w.rs | {16'd0, w.imm});
            CMD_SLTI:  r.value = ($signed(w.rs) < $signed(ext)) ? 32'd1 : 32'd0;
            default:   writes = 1'b0;
        endcase
        r.wr_en = writes & ~w.dz;
        return r;
    endfunction

    function automatic instr_t mk(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] rs,
                                  logic [DATA_W-1:0] rt, logic [IMM_W-1:0] imm,
                                  logic [SH_W-1:0] sh, logic dz);
        instr_t w;
        w.cmd = cmd;
        w.rs = rs;
        w.rt = rt;
        w.imm = imm;
        w.sh = sh;
        w.dz = dz;
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            4: return $urandom_range(0, 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IMM_W-1:0] pick_half();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h8000;
            3: return 16'h7fff;
            default: return IMM_W'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    function automatic instr_t random_instr(logic [CMD_W-1:0] cmd);
        return mk(cmd, pick_word(), pick_word(), pick_half(),
                  SH_W'($urandom_range(0, 31)), ($urandom_range(0, 7) == 0));
    endfunction

    task automatic report_mismatch(string field, logic [DATA_W-1:0] want,
                                   logic [DATA_W-1:0] got);
        $display("MISMATCH %s at %0t: expected %h, got %h", field, $time, want, got);
        error_count++;
    endtask

    task automatic send_instr(instr_t w);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.cmd;
        s_tdata  <= {2'b00, w.dz, w.sh, w.imm, w.rt, w.rs};
        do @(posedge aclk); while (s_tready !== 1'b1);
        exec_results_due.insert(exec_results_due.size(), predict_execute(w));
    endtask

    // Result checker with random stalls and an optional long hold-off
    initial begin : result_monitor
        int gap;
        exec_result_t want;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_hold_cycles > 0) begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                gap = $urandom_range(0, rx_gap_max);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            if (exec_results_due.size() == 0) begin
                report_mismatch("unexpected word", '0, m_tdata[DATA_W-1:0]);
            end else begin
                want = exec_results_due.pop_front();
                if (m_tdata[DATA_W-1:0] !== want.value)
                    report_mismatch("result_value", want.value, m_tdata[DATA_W-1:0]);
                if (m_tdata[M_WE_BIT] !== want.wr_en)
                    report_mismatch("write_enable", DATA_W'(want.wr_en),
                                    DATA_W'(m_tdata[M_WE_BIT]));
                if (m_tdata[M_OVF_BIT] !== want.ovf)
                    report_mismatch("overflow", DATA_W'(want.ovf),
                                    DATA_W'(m_tdata[M_OVF_BIT]));
                if (m_tdata[M_HOV_BIT] !== want.hilo_ovw)
                    report_mismatch("hilo_overwrite", DATA_W'(want.hilo_ovw),
                                    DATA_W'(m_tdata[M_HOV_BIT]));
            end
        end
    end

    task automatic test_alu_corners();
        send_instr(mk(CMD_ADD,   32'h7fff_ffff, 32'h0000_0001, 16'h0000, 5'd0,  1'b0));
        send_instr(mk(CMD_ADD,   32'h8000_0000, 32'h8000_0000, 16'hffff, 5'd31, 1'b1));
        send_instr(mk(CMD_ADDU,  32'hffff_ffff, 32'hffff_ffff, 16'h0000, 5'd0,  1'b0));
        send_instr(mk(CMD_SUB,   32'h8000_0000, 32'h0000_0001, 16'h0000, 5'd0,  1'b0));
        // zero minus the most negative value overflows
        send_instr(mk(CMD_SUB,   32'h0000_0000, 32'h8000_0000, 16'h0000, 5'd0,  1'b0));
        send_instr(mk(CMD_SUB,   32'h7fff_ffff, 32'hffff_ffff, 16'h0000, 5'd0,  1'b0));
        send_instr(mk(CMD_AND,   32'hffff_ffff, 32'h5a5a_a5a5, 16'h0000, 5'd0,  1'b0));
        send_instr(mk(CMD_OR,    32'h0000_0000, 32'h8000_0001, 16'h0000, 5'd0,  1'b0));
        send_instr(mk(CMD_XOR,   32'hffff_ffff, 32'h0f0f_0f0f, 16'h0000, 5'd0,  1'b0));
        send_instr(mk(CMD_NOR,   32'h0000_0000, 32'h0000_0000, 16'h0000, 5'd0,  1'b0));
        send_instr(mk(CMD_NAND,  32'hffff_ffff, 32'hffff_ffff, 16'h0000, 5'd0,  1'b0));
        send_instr(mk(CMD_SLT,   32'h8000_0000, 32'h7fff_ffff, 16'h0000, 5'd0,  1'b0));
        send_instr(mk(CMD_SLL,   32'h0000_0000, 32'hffff_ffff, 16'h0000, 5'd31, 1'b0));
        send_instr(mk(CMD_SRL,   32'h0000_0000, 32'h8000_0000, 16'h0000, 5'd31, 1'b0));
        send_instr(mk(CMD_SRA,   32'h0000_0000, 32'h8000_0000, 16'h0000, 5'd31, 1'b0));
        send_instr(mk(CMD_ADDI,  32'h7fff_ffff, 32'h0000_0000, 16'h7fff, 5'd0,  1'b1));
        send_instr(mk(CMD_ADDIU, 32'h0000_0000, 32'h0000_0000, 16'h8000, 5'd0,  1'b0));
        send_instr(mk(CMD_LUI,   32'h0000_0000, 32'h0000_0000, 16'hffff, 5'd0,  1'b0));
        send_instr(mk(CMD_ANDI,  32'hffff_ffff, 32'h0000_0000, 16'hffff, 5'd0,  1'b0));
        send_instr(mk(CMD_NORI,  32'h0000_0000, 32'h0000_0000, 16'hffff, 5'd0,  1'b0));
        send_instr(mk(CMD_SLTI,  32'hffff_ffff, 32'h0000_0000, 16'h8000, 5'd0,  1'b0));
        send_instr(mk(CMD_UNUSED_LO, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 5'd31, 1'b0));
        send_instr(mk(CMD_UNUSED_HI, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 5'd31, 1'b0));
    endtask

    task automatic test_hilo_sequence();
        send_instr(mk(CMD_MULT,  32'hffff_ffff, 32'hffff_ffff, 16'h0000, 5'd0, 1'b0));
        // second product before any read sets the overwrite flag
        send_instr(mk(CMD_MULTU, 32'hffff_ffff, 32'hffff_ffff, 16'h0000, 5'd0, 1'b0));
        send_instr(mk(CMD_MFHI,  32'h0000_0000, 32'h0000_0000, 16'h0000, 5'd0, 1'b1));
        send_instr(mk(CMD_MULT,  32'h8000_0000, 32'h8000_0000, 16'h0000, 5'd0, 1'b0));
        send_instr(mk(CMD_MFLO,  32'h0000_0000, 32'h0000_0000, 16'h0000, 5'd0, 1'b0));
        send_instr(mk(CMD_MFHI,  32'h0000_0000, 32'h0000_0000, 16'h0000, 5'd0, 1'b0));
    endtask

    task automatic test_random_traffic(int count, int tx_max, int rx_max);
        int sent;
        int extra;
        logic lo_first;
        tx_gap_max = tx_max;
        rx_gap_max = rx_max;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 4) == 0) begin
                // multiply, up to two unrelated ops, then read back HI or LO, mostly both
                send_instr(random_instr($urandom_range(0, 1) ? CMD_MULT : CMD_MULTU));
                extra = $urandom_range(0, 2);
                repeat (extra)
                    send_instr(random_instr(CMD_W'($urandom_range(CMD_ADD, CMD_SRA))));
                lo_first = 1'($urandom_range(0, 1));
                send_instr(random_instr(lo_first ? CMD_MFLO : CMD_MFHI));
                if ($urandom_range(0, 3) != 0)
                    send_instr(random_instr(lo_first ? CMD_MFHI : CMD_MFLO));
                sent += 4;
            end else if ($urandom_range(0, 19) == 0) begin
                send_instr(random_instr(CMD_W'($urandom_range(CMD_UNUSED_LO,
                                                              CMD_UNUSED_HI))));
                sent++;
            end else begin
                send_instr(random_instr(CMD_W'($urandom_range(CMD_ADD, CMD_SLTI))));
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        tx_gap_max = 0;
        rx_gap_max = 0;
        rx_hold_cycles = 80;
        repeat (24) send_instr(random_instr(CMD_W'($urandom_range(CMD_ADD, CMD_SLTI))));
        rx_gap_max = 12;
        repeat (20) send_instr(random_instr(CMD_W'($urandom_range(CMD_ADD, CMD_SLTI))));
    endtask

    initial begin
        error_count = 0;
        tx_gap_max = 12;
        rx_gap_max = 12;
        rx_hold_cycles = 0;
        hi_copy = '0;
        lo_copy = '0;
        product_unread = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_alu_corners();
        test_hilo_sequence();
        test_random_traffic(900, 12, 12);
        test_random_traffic(350, 0, 0);
        test_random_traffic(350, 12, 0);
        test_random_traffic(350, 0, 12);
        test_backpressure();
        s_tvalid <= 1'b0;

        while (exec_results_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
